// ===== design/buddy_page_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared concurrent assertion shorthands for the checker.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BPA_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BPA_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/bpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Beat payload types, command and status codes.
// ---------------------------------------------------------------------------
package bpa_pkg;

    localparam int CMD_W    = 2;
    localparam int REQ_W    = 12;
    localparam int OFF_W    = 10;
    localparam int STAT_W   = 3;
    localparam int PAGES_W  = 11;

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_REQ = 3'd1;
    localparam logic [STAT_W-1:0] ST_OVER_CNT = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_INIT  = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_FREE = 3'd5;

    localparam logic [PAGES_W-1:0] MANAGED_RST = 11'd1024;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [REQ_W-1:0] page_count;
        logic [OFF_W-1:0] page_offset;
    } t_bpa_in;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   block_offset;
        logic [PAGES_W-1:0] block_pages;
        logic [PAGES_W-1:0] free_total;
    } t_bpa_out;

endpackage

// ===== design/bpa_ram.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator RAM
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/buddy_page_allocator.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy allocator over a longest-free-run tree held in one RAM.
// ---------------------------------------------------------------------------
// One command beat in, one result beat out. The tree of 2*LEAVES-1 nodes
// lives in a 1W1R RAM with registered read data, and every tree level
// costs a read and a compare, for a tree depth L=log2(LEAVES). An alloc of
// a block of size 2^k descends, then repairs the ancestors; a free climbs
// to the cleared node, then merges back up; init writes every node once;
// an alloc with no fitting run stops after the root read; errors caught
// on arrival and the unused command go straight to the result. One command
// is in work at a time; the result register lets the next command beat in
// while the previous result still waits. The tree content is undefined after
// reset until the first init; alloc and free report not-initialized until then.
// Config writes are taken any cycle; the user must write them only while
// the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module buddy_page_allocator #(
    parameter int LEAVES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bpa_pkg::t_bpa_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bpa_pkg::t_bpa_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [10:0]       i_cfg_data
);
    import bpa_pkg::*;

    localparam int OW = $clog2(LEAVES);      // page offset bits
    localparam int LW = OW + 1;              // node value bits (0..LEAVES)
    localparam int IW = OW + 1;              // node index bits
    localparam int CW = (LW > REQ_W) ? LW : REQ_W;
    localparam int NODES = 2 * LEAVES - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_AROOT_RD, S_AROOT, S_ADRD, S_AD, S_AWR,
        S_FRD, S_FCHK, S_CRD, S_CWR, S_DONE
    } t_state;

    function automatic logic [LW-1:0] hibit(input logic [LW-1:0] x);
        logic [LW-1:0] r;
        r = '0;
        for (int b = 0; b < LW; b++) begin
            if (x[b]) r = LW'(1) << b;
        end
        return r;
    endfunction

    t_state           r_state;
    logic [PAGES_W-1:0] r_managed;
    logic             r_ready;       // tree built
    logic [LW-1:0]    r_free;
    logic [LW-1:0]    r_count;       // pages latched at init
    logic [IW-1:0]    r_idx;
    logic [LW-1:0]    r_size;
    logic [LW-1:0]    r_need;
    logic [LW-1:0]    r_val;         // new value of node r_idx
    logic [OW-1:0]    r_off;
    logic             r_merge;       // free climb: buddies merge
    logic [LW-1:0]    r_a;           // init: level position
    logic [STAT_W-1:0]  r_status;
    logic [OFF_W-1:0]   r_boff;
    logic [PAGES_W-1:0] r_bpages;
    logic             r_out_valid;
    t_bpa_out         r_out;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [LW-1:0]    ram_wdata;
    logic [IW-1:0]    ram_raddr;
    logic [LW-1:0]    rd;

    bpa_ram #(.WIDTH(LW), .DEPTH(NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // init: node covering [a, a+s) holds s when full, else the top power of
    // two of its free prefix
    logic [LW-1:0] init_f, init_v, init_an;
    assign init_f  = (r_count > r_a) ? (r_count - r_a) : '0;
    assign init_v  = (init_f >= r_size) ? r_size : hibit(init_f);
    assign init_an = r_a + r_size;

    // tree neighbors of r_idx
    logic [IW-1:0] kid_l, sib, parent;
    logic [LW-1:0] psz, cmax, cval;
    logic [LW:0]   csum;
    assign kid_l  = {r_idx[IW-2:0], 1'b1};
    assign sib    = r_idx[0] ? (r_idx + IW'(1)) : (r_idx - IW'(1));
    assign parent = (r_idx - IW'(1)) >> 1;
    assign psz    = r_size << 1;
    assign cmax   = (r_val > rd) ? r_val : rd;
    assign csum   = {1'b0, r_val} + {1'b0, rd};
    assign cval   = (r_merge && (csum == {1'b0, psz})) ? psz : cmax;

    // decode of an arriving command
    logic [LW-1:0] req_t, need_in, cnt_sat;
    assign req_t   = LW'(i_in_data.page_count);
    assign need_in = (req_t <= LW'(1)) ? LW'(1) : (hibit(req_t - LW'(1)) << 1);
    assign cnt_sat = (CW'(r_managed) > CW'(LEAVES)) ? LW'(LEAVES) : LW'(r_managed);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_raddr = r_idx;
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = init_v;
            end
            S_AROOT_RD: ram_raddr = '0;
            S_ADRD:     ram_raddr = kid_l;
            S_AWR:      ram_we    = 1'b1;
            S_FCHK: begin
                ram_we    = (rd == '0);
                ram_wdata = r_size;
            end
            S_CRD:      ram_raddr = sib;
            S_CWR: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = cval;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_managed   <= MANAGED_RST;
            r_ready     <= 1'b0;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_managed <= i_cfg_data;
            end
            // result register: load from DONE, drop on handshake
            if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_boff   <= '0;
                        r_bpages <= '0;
                        r_need   <= need_in;
                        case (i_in_data.command)
                            CMD_INIT: begin
                                r_status <= ST_OK;
                                r_idx    <= '0;
                                r_size   <= LW'(LEAVES);
                                r_off    <= '0;
                                r_count  <= cnt_sat;
                                r_a      <= '0;
                                r_state  <= S_INIT;
                            end
                            CMD_ALLOC: begin
                                r_idx  <= '0;
                                r_size <= LW'(LEAVES);
                                r_off  <= '0;
                                if (!r_ready) begin
                                    r_status <= ST_NO_INIT;
                                    r_state  <= S_DONE;
                                end else if (i_in_data.page_count == '0) begin
                                    r_status <= ST_ZERO_REQ;
                                    r_state  <= S_DONE;
                                end else if (CW'(i_in_data.page_count) > CW'(r_free)) begin
                                    r_status <= ST_OVER_CNT;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_AROOT_RD;
                                end
                            end
                            CMD_FREE: begin
                                r_idx  <= IW'(i_in_data.page_offset) + IW'(LEAVES - 1);
                                r_size <= LW'(1);
                                r_off  <= OW'(i_in_data.page_offset);
                                if (!r_ready) begin
                                    r_status <= ST_NO_INIT;
                                    r_state  <= S_DONE;
                                end else if (CW'(i_in_data.page_offset) >= CW'(r_count)) begin
                                    r_status <= ST_BAD_FREE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_FRD;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    // one node per cycle, level by level from the root
                    r_idx <= r_idx + IW'(1);
                    if (init_an == LW'(LEAVES)) begin
                        r_a    <= '0;
                        r_size <= r_size >> 1;
                    end else begin
                        r_a <= init_an;
                    end
                    if (r_idx == IW'(NODES - 1)) begin
                        r_ready <= 1'b1;
                        r_free  <= r_count;
                        r_state <= S_DONE;
                    end
                end
                S_AROOT_RD: r_state <= S_AROOT;
                S_AROOT: begin
                    if (rd < r_need) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_DONE;
                    end else if (r_size == r_need) begin
                        r_state <= S_AWR;
                    end else begin
                        r_state <= S_ADRD;
                    end
                end
                S_ADRD: r_state <= S_AD;
                S_AD: begin
                    // left child first
                    if (rd >= r_need) begin
                        r_idx <= kid_l;
                    end else begin
                        r_idx <= kid_l + IW'(1);
                        r_off <= r_off | OW'(r_size >> 1);
                    end
                    r_size  <= r_size >> 1;
                    r_state <= ((r_size >> 1) == r_need) ? S_AWR : S_ADRD;
                end
                S_AWR: begin
                    r_boff   <= OFF_W'(r_off);
                    r_bpages <= PAGES_W'(r_size);
                    r_free   <= r_free - r_need;
                    r_val    <= '0;
                    r_merge  <= 1'b0;
                    r_state  <= (r_idx == '0) ? S_DONE : S_CRD;
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (rd != '0) begin
                        if (r_idx == '0) begin
                            r_status <= ST_BAD_FREE;
                            r_state  <= S_DONE;
                        end else begin
                            r_idx   <= parent;
                            r_size  <= psz;
                            r_state <= S_FRD;
                        end
                    end else begin
                        // cleared node found: restored by the RAM write now
                        r_boff   <= OFF_W'(r_off & ~OW'(r_size - LW'(1)));
                        r_bpages <= PAGES_W'(r_size);
                        r_free   <= r_free + r_size;
                        r_val    <= r_size;
                        r_merge  <= 1'b1;
                        r_state  <= (r_idx == '0) ? S_DONE : S_CRD;
                    end
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    r_idx   <= parent;
                    r_val   <= cval;
                    r_size  <= psz;
                    r_state <= (parent == '0) ? S_DONE : S_CRD;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.status       <= r_status;
                        r_out.block_offset <= r_boff;
                        r_out.block_pages  <= r_bpages;
                        r_out.free_total   <= PAGES_W'(r_free);
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== design/bpa_checker.sv =====
// ---------------------------------------------------------------------------
// Buddy page allocator checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_port_assert #(
    parameter int LEAVES = 1024
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input bpa_pkg::t_bpa_out o_out_data
);
    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")
    `BPA_ASSERT_NOW(a_err_zero, o_out_valid && (o_out_data.status != ST_OK), (o_out_data.block_pages == '0) && (o_out_data.block_offset == '0), "error result carries a block")
    `BPA_ASSERT_NOW(a_free_bound, o_out_valid, 32'(o_out_data.free_total) <= 32'(LEAVES), "free count above page total")
    `BPA_ASSERT_NOW(a_stat_range, o_out_valid, o_out_data.status <= ST_BAD_FREE, "unknown status code")

endmodule

bind buddy_page_allocator bpa_port_assert #(.LEAVES(LEAVES)) u_bpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
